@@ hw/rtl/vmb_pkg.sv @@
package vmb_pkg;

  // bus address map
  localparam int unsigned AddrWidth  = 14;
  localparam int unsigned DataWidth  = 8;
  localparam int unsigned NtIdxWidth = 12;
  localparam int unsigned PalDepth   = 32;
  localparam int unsigned PalIdxWidth = 5;

  localparam logic [AddrWidth-1:0] NtStart  = 14'h2000;
  localparam logic [AddrWidth-1:0] PalStart = 14'h3F00;

  // access operation codes
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  typedef enum logic [1:0] {
    MIRROR_HORIZONTAL = 2'd0,
    MIRROR_VERTICAL   = 2'd1,
    MIRROR_SINGLE     = 2'd2,
    MIRROR_FOUR       = 2'd3
  } mirror_e;

  // decoded access, passed from the address decoder to the top level
  typedef struct packed {
    logic                   nt_en;
    logic                   pal_en;
    logic                   we;
    logic                   pattern;
    logic [NtIdxWidth-1:0]  nt_idx;
    logic [PalIdxWidth-1:0] pal_idx;
  } access_t;

endpackage

@@ hw/rtl/vmb_in_if.sv @@
interface vmb_in_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic [vmb_pkg::AddrWidth-1:0]      address;
  logic [vmb_pkg::DataWidth-1:0]      write_data;

  modport source (output valid, output operation, output address, output write_data,
                  input ready);
  modport sink   (input valid, input operation, input address, input write_data,
                  output ready);
endinterface

@@ hw/rtl/vmb_out_if.sv @@
interface vmb_out_if;
  logic                               valid;
  logic                               ready;
  logic [vmb_pkg::DataWidth-1:0]      read_data;
  logic                               pattern_access;

  modport source (output valid, output read_data, output pattern_access, input ready);
  modport sink   (input valid, input read_data, input pattern_access, output ready);
endinterface

@@ hw/rtl/vmb_ram.sv @@
module vmb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/vmb_decode.sv @@
module vmb_decode (
  input  vmb_pkg::mirror_e                 mode_i,
  input  logic                             operation_i,
  input  logic [vmb_pkg::AddrWidth-1:0]    address_i,
  output vmb_pkg::access_t                 access_o
);

  logic                                reading;
  logic [vmb_pkg::PalIdxWidth-1:0]     pal_idx;

  assign reading = (operation_i == vmb_pkg::OpRead);

  always_comb begin
    // region select
    access_o.we      = (operation_i == vmb_pkg::OpWrite);
    access_o.pattern = reading && (address_i < vmb_pkg::NtStart);
    access_o.pal_en  = (address_i >= vmb_pkg::PalStart);
    access_o.nt_en   = (address_i >= vmb_pkg::NtStart) && (address_i < vmb_pkg::PalStart);

    // nametable folding by mirroring mode
    unique case (mode_i)
      vmb_pkg::MIRROR_HORIZONTAL: access_o.nt_idx = {1'b0, address_i[11], address_i[9:0]};
      vmb_pkg::MIRROR_VERTICAL:   access_o.nt_idx = {1'b0, address_i[10:0]};
      vmb_pkg::MIRROR_SINGLE:     access_o.nt_idx = {2'b00, address_i[9:0]};
      default:                    access_o.nt_idx = address_i[11:0];
    endcase

    // palette folding: upper backdrop entries alias down, reads of 4/8/c see entry 0
    pal_idx = address_i[4:0];
    if (pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
      pal_idx[4] = 1'b0;
    end
    if (reading && !pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
      pal_idx[3:2] = 2'b00;
    end
    access_o.pal_idx = pal_idx;
  end

endmodule

@@ hw/rtl/video_memory_mirroring_bus.sv @@
// Video memory bus with nametable and palette mirroring.
// The in_i channel carries one transaction per access: operation (read or
// write), 14-bit address and write data. The out_o channel returns one result
// per transaction: read_data and pattern_access. Both use valid/ready.
// cfg_we_i/cfg_wdata_i set the mirroring mode; the user must write them only
// while the bus is idle, as the block does not enforce it. Pattern space
// below 0x2000 is not stored here: writes are dropped, reads return zero with
// pattern_access set. Nametable and palette RAM are single port memories
// with registered read, accessed in the cycle of acceptance. Latency: the
// result is valid in the cycle after the transaction is taken. Throughput:
// one transaction per clock when not stalled; RAM is used only on accept.
// Reset clears the mirroring mode to horizontal and empties the result
// register; RAM contents stay undefined until written.
// When the receiver stalls, the result holds and in_i.ready stays low until
// it is taken; a result taken in a cycle frees room for a new transaction in
// that same cycle.
module video_memory_mirroring_bus #(
  parameter int unsigned NAMETABLE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  vmb_in_if.sink      in_i,
  vmb_out_if.source   out_o
);

  localparam int unsigned NtAw = $clog2(NAMETABLE_DEPTH);
  localparam logic [vmb_pkg::NtIdxWidth:0] NtDepthW = (vmb_pkg::NtIdxWidth+1)'(NAMETABLE_DEPTH);

  vmb_pkg::mirror_e                 mode_q;
  vmb_pkg::access_t                 access;
  logic                             accept;
  logic [vmb_pkg::NtIdxWidth:0]     nt_wide;
  logic [vmb_pkg::NtIdxWidth:0]     nt_wrap;
  logic [vmb_pkg::DataWidth-1:0]    nt_rdata;
  logic [vmb_pkg::DataWidth-1:0]    pal_rdata;
  logic                             valid_q;
  logic                             nt_rd_q;
  logic                             pal_rd_q;
  logic                             pattern_q;

  // mirroring mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= vmb_pkg::MIRROR_HORIZONTAL;
    end else if (cfg_we_i) begin
      mode_q <= vmb_pkg::mirror_e'(cfg_wdata_i);
    end
  end

  vmb_decode u_decode (
    .mode_i      (mode_q),
    .operation_i (in_i.operation),
    .address_i   (in_i.address),
    .access_o    (access)
  );

  assign in_i.ready = !valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // wrap the folded index into a smaller nametable
  assign nt_wide = {1'b0, access.nt_idx};
  assign nt_wrap = (nt_wide >= NtDepthW) ? (nt_wide - NtDepthW) : nt_wide;

  vmb_ram #(
    .Width (vmb_pkg::DataWidth),
    .Depth (NAMETABLE_DEPTH)
  ) u_nt_ram (
    .clk_i   (clk_i),
    .en_i    (accept && access.nt_en),
    .we_i    (access.we),
    .addr_i  (nt_wrap[NtAw-1:0]),
    .wdata_i (in_i.write_data),
    .rdata_o (nt_rdata)
  );

  vmb_ram #(
    .Width (vmb_pkg::DataWidth),
    .Depth (vmb_pkg::PalDepth)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .en_i    (accept && access.pal_en),
    .we_i    (access.we),
    .addr_i  (access.pal_idx),
    .wdata_i (in_i.write_data),
    .rdata_o (pal_rdata)
  );

  // result register: valid and source select for the returned byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      nt_rd_q   <= 1'b0;
      pal_rd_q  <= 1'b0;
      pattern_q <= 1'b0;
    end else if (accept) begin
      valid_q   <= 1'b1;
      nt_rd_q   <= access.nt_en && !access.we;
      pal_rd_q  <= access.pal_en && !access.we;
      pattern_q <= access.pattern;
    end else if (out_o.ready) begin
      valid_q   <= 1'b0;
    end
  end

  // output select
  assign out_o.valid          = valid_q;
  assign out_o.pattern_access = pattern_q;
  assign out_o.read_data      = nt_rd_q  ? nt_rdata :
                                pal_rd_q ? pal_rdata : '0;

`ifndef SYNTH
  a_accept_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_o.valid)
    else $error("accepted transaction produced no result");

  a_ready_only_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input blocked without an output stall");

  a_pattern_reads_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.pattern_access) |-> (out_o.read_data == '0))
    else $error("pattern access returned nonzero data");

  a_one_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> $onehot0({nt_rd_q, pal_rd_q, pattern_q}))
    else $error("result selects more than one source");
`endif

endmodule

@@ dv/video_memory_mirroring_bus_test.sv @@
module video_memory_mirroring_bus_test;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected bus response
  typedef struct {
    logic [vmb_pkg::DataWidth-1:0] read_data;
    logic                          pattern_access;
  } bus_response_t;

  // mirror of the bus memories and the queue of pending responses
  class access_scoreboard;
    vmb_pkg::mirror_e              mode;
    logic [vmb_pkg::DataWidth-1:0] nt_mem [4096];
    bit                            nt_written [4096];
    logic [vmb_pkg::DataWidth-1:0] pal_mem [vmb_pkg::PalDepth];
    bit                            pal_written [vmb_pkg::PalDepth];
    bus_response_t                 pending_q [$];
    int                            errors;

    function new();
      mode   = vmb_pkg::MIRROR_HORIZONTAL;
      errors = 0;
    endfunction

    // fold a nametable address by the current mirroring mode
    function logic [vmb_pkg::NtIdxWidth-1:0] nt_index(logic [vmb_pkg::AddrWidth-1:0] a);
      logic [vmb_pkg::NtIdxWidth-1:0] idx;
      case (mode)
        vmb_pkg::MIRROR_HORIZONTAL: idx = {1'b0, a[11], a[9:0]};
        vmb_pkg::MIRROR_VERTICAL:   idx = {1'b0, a[10:0]};
        vmb_pkg::MIRROR_SINGLE:     idx = {2'b00, a[9:0]};
        default:                    idx = a[11:0];
      endcase
      return idx;
    endfunction

    // palette folding: upper backdrop entries alias down, reads of 4/8/c see entry 0
    function logic [vmb_pkg::PalIdxWidth-1:0] pal_index(logic [vmb_pkg::AddrWidth-1:0] a,
                                                        bit reading);
      logic [vmb_pkg::PalIdxWidth-1:0] idx;
      idx = a[vmb_pkg::PalIdxWidth-1:0];
      if (idx[4] && idx[1:0] == 2'b00) idx[4] = 1'b0;
      if (reading && idx[1:0] == 2'b00 && idx[3:2] != 2'b00) idx = '0;
      return idx;
    endfunction

    // true when a read at this address touches only written storage
    function bit readable(logic [vmb_pkg::AddrWidth-1:0] a);
      if (a < vmb_pkg::NtStart) return 1'b1;
      if (a < vmb_pkg::PalStart) return nt_written[nt_index(a)];
      return pal_written[pal_index(a, 1'b1)];
    endfunction

    // apply one accepted transaction and queue its response
    function void note_access(logic op, logic [vmb_pkg::AddrWidth-1:0] a,
                              logic [vmb_pkg::DataWidth-1:0] d);
      bus_response_t rsp;
      rsp.read_data      = '0;
      rsp.pattern_access = 1'b0;
      if (op == vmb_pkg::OpWrite) begin
        if (a >= vmb_pkg::PalStart) begin
          pal_mem[pal_index(a, 1'b0)]     = d;
          pal_written[pal_index(a, 1'b0)] = 1'b1;
        end else if (a >= vmb_pkg::NtStart) begin
          nt_mem[nt_index(a)]     = d;
          nt_written[nt_index(a)] = 1'b1;
        end
      end else begin
        if (a < vmb_pkg::NtStart) rsp.pattern_access = 1'b1;
        else if (a < vmb_pkg::PalStart) rsp.read_data = nt_mem[nt_index(a)];
        else rsp.read_data = pal_mem[pal_index(a, 1'b1)];
      end
      pending_q.push_back(rsp);
    endfunction

    // compare one returned response with the oldest pending one
    function void check_result(logic [vmb_pkg::DataWidth-1:0] rd, logic pat);
      bus_response_t exp_rsp;
      if (pending_q.size() == 0) begin
        $error("unexpected response: read_data %0h, pattern_access %0b", rd, pat);
        errors++;
        return;
      end
      exp_rsp = pending_q.pop_front();
      if (rd !== exp_rsp.read_data) begin
        $error("read_data mismatch: expected %0h, actual %0h", exp_rsp.read_data, rd);
        errors++;
      end
      if (pat !== exp_rsp.pattern_access) begin
        $error("pattern_access mismatch: expected %0b, actual %0b",
               exp_rsp.pattern_access, pat);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;

  vmb_in_if  in_bus ();
  vmb_out_if out_bus ();

  access_scoreboard sb = new();

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int hold_cycles  = 0;

  video_memory_mirroring_bus DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // response side: random stalls, long hold-off on request
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready)
        sb.check_result(out_bus.read_data, out_bus.pattern_access);
      if (hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one transaction, with random idle cycles ahead of it
  task automatic send_access(input logic op, input logic [vmb_pkg::AddrWidth-1:0] a,
                             input logic [vmb_pkg::DataWidth-1:0] d);
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_bus.valid      <= 1'b1;
    in_bus.operation  <= op;
    in_bus.address    <= a;
    in_bus.write_data <= d;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sb.note_access(op, a, d);
  endtask

  // stop offering and wait for every pending response
  task automatic drain_bus();
    in_bus.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_mirroring(input vmb_pkg::mirror_e m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.mode = m;
  endtask

  // random access, partly clustered; a read of unwritten storage becomes a write
  task automatic random_access();
    logic                          op;
    logic [vmb_pkg::AddrWidth-1:0] a;
    logic [vmb_pkg::DataWidth-1:0] d;
    int                            sel;
    for (int tries = 0; tries < 8; tries++) begin
      op  = 1'($urandom_range(1));
      sel = $urandom_range(99);
      if (sel < 12) a = (vmb_pkg::AddrWidth)'($urandom_range(14'h1FFF));
      else if (sel < 32) a = (vmb_pkg::AddrWidth)'($urandom_range(14'h3EFF, 14'h2000));
      else if (sel < 70)
        a = (vmb_pkg::AddrWidth)'(32'h2000 | ($urandom_range(1) << 12)
            | ($urandom_range(3) << 10) | $urandom_range(31));
      else a = (vmb_pkg::AddrWidth)'(32'h3F00 + $urandom_range(255));
      if (op == vmb_pkg::OpWrite || sb.readable(a)) break;
    end
    if (op == vmb_pkg::OpRead && !sb.readable(a)) op = vmb_pkg::OpWrite;
    d = (vmb_pkg::DataWidth)'($urandom_range(255));
    send_access(op, a, d);
  endtask

  task automatic run_phase(input vmb_pkg::mirror_e m, input int gap_pct, input int stl_pct,
                           input int n_items, input int hold);
    drain_bus();
    set_mirroring(m);
    send_gap_pct = gap_pct;
    stall_pct    = stl_pct;
    hold_cycles  = hold;
    repeat (n_items) random_access();
  endtask

  // main sequence
  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.operation  <= vmb_pkg::OpRead;
    in_bus.address    <= '0;
    in_bus.write_data <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: address extremes, pattern space, mirrors and palette aliasing
    set_mirroring(vmb_pkg::MIRROR_HORIZONTAL);
    send_access(vmb_pkg::OpWrite, 14'h2000, 8'h00);
    send_access(vmb_pkg::OpWrite, 14'h3EFF, 8'hFF);
    send_access(vmb_pkg::OpRead,  14'h0000, 8'hFF);
    send_access(vmb_pkg::OpRead,  14'h1FFF, 8'h00);
    send_access(vmb_pkg::OpWrite, 14'h1ABC, 8'hA5);
    send_access(vmb_pkg::OpWrite, 14'h0000, 8'hFF);
    send_access(vmb_pkg::OpRead,  14'h2000, 8'h00);
    send_access(vmb_pkg::OpRead,  14'h2400, 8'h00);
    send_access(vmb_pkg::OpRead,  14'h3400, 8'h00);
    send_access(vmb_pkg::OpRead,  14'h2EFF, 8'h00);
    send_access(vmb_pkg::OpWrite, 14'h2C00, 8'h5A);
    send_access(vmb_pkg::OpRead,  14'h3800, 8'h00);
    send_access(vmb_pkg::OpWrite, 14'h3F00, 8'h11);
    send_access(vmb_pkg::OpWrite, 14'h3F10, 8'h22);
    send_access(vmb_pkg::OpRead,  14'h3F00, 8'h00);
    send_access(vmb_pkg::OpWrite, 14'h3F04, 8'h33);
    send_access(vmb_pkg::OpRead,  14'h3F04, 8'h00);
    send_access(vmb_pkg::OpRead,  14'h3F14, 8'h00);
    send_access(vmb_pkg::OpWrite, 14'h3F1F, 8'h7E);
    send_access(vmb_pkg::OpRead,  14'h3FFF, 8'h00);
    send_access(vmb_pkg::OpRead,  14'h3F10, 8'h00);
    send_access(vmb_pkg::OpWrite, 14'h3F08, 8'h44);
    send_access(vmb_pkg::OpRead,  14'h3F18, 8'h00);
    send_access(vmb_pkg::OpWrite, 14'h3F01, 8'hC3);
    send_access(vmb_pkg::OpRead,  14'h3F21, 8'h00);

    // random phases over all mirroring modes and idling profiles
    run_phase(vmb_pkg::MIRROR_VERTICAL,   0,  0,  100, 0);
    run_phase(vmb_pkg::MIRROR_FOUR,       70, 0,  90,  0);
    run_phase(vmb_pkg::MIRROR_SINGLE,     0,  70, 90,  0);
    run_phase(vmb_pkg::MIRROR_HORIZONTAL, 23, 23, 90,  0);
    // long receiver hold-off while the sender keeps offering
    run_phase(vmb_pkg::MIRROR_FOUR,       0,  0,  90,  300);
    run_phase(vmb_pkg::mirror_e'($urandom_range(3)), 23, 23, 90, 0);

    drain_bus();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ video_memory_mirroring_bus.f @@
hw/rtl/vmb_pkg.sv
hw/rtl/vmb_in_if.sv
hw/rtl/vmb_out_if.sv
hw/rtl/vmb_ram.sv
hw/rtl/vmb_decode.sv
hw/rtl/video_memory_mirroring_bus.sv
dv/video_memory_mirroring_bus_test.sv
